// ===== design/tpsc_pkg.sv =====
// ---------------------------------------------------------------------------
// tpsc_pkg
// Shared types, constants and microcode encodings for the touch plate
// PD servo controller.
// ---------------------------------------------------------------------------
`default_nettype none

package tpsc_pkg;

  // Plate geometry and thresholds
  localparam int unsigned PLATE_WIDTH_MM  = 165;
  localparam int unsigned PLATE_HEIGHT_MM = 105;
  localparam int unsigned TOUCH_THRESHOLD = 125;
  localparam int unsigned PWM_TOP         = 37499;

  // Plate centre in mm with 8 fraction bits (integer mm only)
  localparam logic [15:0] CENTER_X = 16'((PLATE_WIDTH_MM / 2) * 256);
  localparam logic [15:0] CENTER_Y = 16'((PLATE_HEIGHT_MM / 2) * 256);

  // Register reset values
  localparam logic [15:0] RST_SETPOINT_X = 16'd21120;
  localparam logic [14:0] RST_SETPOINT_Y = 15'd13440;
  localparam logic [15:0] RST_PROP_GAIN  = 16'd256;
  localparam logic [15:0] RST_DERIV_GAIN = 16'd26;
  localparam logic [9:0]  RST_X_CPM      = 10'd75;
  localparam logic [9:0]  RST_Y_CPM      = 10'd50;
  localparam logic [15:0] RST_X_LEVEL    = 16'd3750;
  localparam logic [15:0] RST_Y_LEVEL    = 16'd3750;

  // Register indexes
  localparam logic [2:0] REG_SETPOINT_X = 3'd0;
  localparam logic [2:0] REG_SETPOINT_Y = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN  = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [2:0] REG_X_CPM      = 3'd4;
  localparam logic [2:0] REG_Y_CPM      = 3'd5;
  localparam logic [2:0] REG_X_LEVEL    = 3'd6;
  localparam logic [2:0] REG_Y_LEVEL    = 3'd7;

  // Datapath widths
  localparam int unsigned ERR_W  = 17;               // position error, signed
  localparam int unsigned ACC_W  = 35;               // PD term, signed
  localparam int unsigned PROD_W = ACC_W + 17;       // multiplier result, signed

  // Sequencer step
  localparam int unsigned STEP_W = 4;

  // Jump conditions
  localparam logic [1:0] JC_NONE     = 2'd0;   // go to target
  localparam logic [1:0] JC_WAIT_IN  = 2'd1;   // hold until tick transfer
  localparam logic [1:0] JC_WAIT_OUT = 2'd2;   // hold until result slot free

  // Multiplier A operand
  localparam logic [1:0] A_ERR  = 2'd0;
  localparam logic [1:0] A_DIFF = 2'd1;
  localparam logic [1:0] A_ACC  = 2'd2;

  // Multiplier B operand
  localparam logic [1:0] B_PGAIN = 2'd0;
  localparam logic [1:0] B_DGAIN = 2'd1;
  localparam logic [1:0] B_CPM   = 2'd2;

  // Accumulator operations
  localparam logic [2:0] ACC_NOP   = 3'd0;
  localparam logic [2:0] ACC_LOAD  = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_NLOAD = 3'd3;
  localparam logic [2:0] ACC_SUB   = 3'd4;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Payload types
  typedef struct packed {
    logic [11:0] pressure_code;
    logic [11:0] x_code;
    logic [11:0] y_code;
  } tick_t;

  typedef struct packed {
    logic [15:0] x_servo_compare;
    logic [15:0] y_servo_compare;
    logic        touched;
  } result_t;

  // Configuration register file
  typedef struct packed {
    logic [15:0] setpoint_x;
    logic [14:0] setpoint_y;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [9:0]  x_cpm;
    logic [9:0]  y_cpm;
    logic [15:0] x_level;
    logic [15:0] y_level;
  } cfg_t;

  // One microcode word
  typedef struct packed {
    logic [1:0]        jcond;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    logic [1:0]        a_sel;
    logic [1:0]        b_sel;
    logic              axis;
    logic [2:0]        acc_op;
    logic              out_x;
    logic              out_y;
    logic              emit;
  } ucw_t;

endpackage

`default_nettype wire

// ===== design/tpsc_ucode_rom.sv =====
// ---------------------------------------------------------------------------
// tpsc_ucode_rom
// Control store: one microcode word per sequencer step.
// ---------------------------------------------------------------------------
`default_nettype none

module tpsc_ucode_rom
  import tpsc_pkg::*;
(
  input  wire logic [STEP_W-1:0] step,
  output ucw_t                   word
);

  function automatic ucw_t mk(input logic [1:0] jc, input logic [STEP_W-1:0] tgt,
                              input logic me, input logic [1:0] as, input logic [1:0] bs,
                              input logic ax, input logic [2:0] ao, input logic ox,
                              input logic oy, input logic em);
    ucw_t w;
    w.jcond  = jc;
    w.target = tgt;
    w.mul_en = me;
    w.a_sel  = as;
    w.b_sel  = bs;
    w.axis   = ax;
    w.acc_op = ao;
    w.out_x  = ox;
    w.out_y  = oy;
    w.emit   = em;
    return w;
  endfunction

  // x axis in steps 1..5, y axis (negated PD term) in steps 6..10
  always_comb begin
    unique case (step)
      4'd0:  word = mk(JC_WAIT_IN, 4'd1, 1'b0, A_ERR, B_PGAIN, AXIS_X, ACC_NOP,
                       1'b0, 1'b0, 1'b0);
      4'd1:  word = mk(JC_NONE, 4'd2, 1'b1, A_ERR, B_PGAIN, AXIS_X, ACC_NOP,
                       1'b0, 1'b0, 1'b0);
      4'd2:  word = mk(JC_NONE, 4'd3, 1'b1, A_DIFF, B_DGAIN, AXIS_X, ACC_LOAD,
                       1'b0, 1'b0, 1'b0);
      4'd3:  word = mk(JC_NONE, 4'd4, 1'b0, A_ERR, B_PGAIN, AXIS_X, ACC_ADD,
                       1'b0, 1'b0, 1'b0);
      4'd4:  word = mk(JC_NONE, 4'd5, 1'b1, A_ACC, B_CPM, AXIS_X, ACC_NOP,
                       1'b0, 1'b0, 1'b0);
      4'd5:  word = mk(JC_NONE, 4'd6, 1'b0, A_ERR, B_PGAIN, AXIS_X, ACC_NOP,
                       1'b1, 1'b0, 1'b0);
      4'd6:  word = mk(JC_NONE, 4'd7, 1'b1, A_ERR, B_PGAIN, AXIS_Y, ACC_NOP,
                       1'b0, 1'b0, 1'b0);
      4'd7:  word = mk(JC_NONE, 4'd8, 1'b1, A_DIFF, B_DGAIN, AXIS_Y, ACC_NLOAD,
                       1'b0, 1'b0, 1'b0);
      4'd8:  word = mk(JC_NONE, 4'd9, 1'b0, A_ERR, B_PGAIN, AXIS_Y, ACC_SUB,
                       1'b0, 1'b0, 1'b0);
      4'd9:  word = mk(JC_NONE, 4'd10, 1'b1, A_ACC, B_CPM, AXIS_Y, ACC_NOP,
                       1'b0, 1'b0, 1'b0);
      4'd10: word = mk(JC_NONE, 4'd11, 1'b0, A_ERR, B_PGAIN, AXIS_Y, ACC_NOP,
                       1'b0, 1'b1, 1'b0);
      4'd11: word = mk(JC_WAIT_OUT, 4'd0, 1'b0, A_ERR, B_PGAIN, AXIS_X, ACC_NOP,
                       1'b0, 1'b0, 1'b1);
      default: word = mk(JC_NONE, 4'd0, 1'b0, A_ERR, B_PGAIN, AXIS_X, ACC_NOP,
                         1'b0, 1'b0, 1'b0);
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tpsc_datapath.sv =====
// ---------------------------------------------------------------------------
// tpsc_datapath
// Config registers, error registers, shared multiplier, accumulator and
// compare saturation, all steered by the microcode word.
// ---------------------------------------------------------------------------
`default_nettype none

module tpsc_datapath
  import tpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        tick_fire,
  input  wire tick_t       tick,
  input  wire logic        emit_fire,
  input  wire ucw_t        word,
  output result_t          res
);

  cfg_t cfg;

  logic signed [ERR_W-1:0]  ex, ey, px, py;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic [15:0]              res_x, res_y;
  logic                     touched;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_x <= RST_SETPOINT_X;
      cfg.setpoint_y <= RST_SETPOINT_Y;
      cfg.prop_gain  <= RST_PROP_GAIN;
      cfg.deriv_gain <= RST_DERIV_GAIN;
      cfg.x_cpm      <= RST_X_CPM;
      cfg.y_cpm      <= RST_Y_CPM;
      cfg.x_level    <= RST_X_LEVEL;
      cfg.y_level    <= RST_Y_LEVEL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT_X: cfg.setpoint_x <= cfg_data;
        REG_SETPOINT_Y: cfg.setpoint_y <= cfg_data[14:0];
        REG_PROP_GAIN:  cfg.prop_gain  <= cfg_data;
        REG_DERIV_GAIN: cfg.deriv_gain <= cfg_data;
        REG_X_CPM:      cfg.x_cpm      <= cfg_data[9:0];
        REG_Y_CPM:      cfg.y_cpm      <= cfg_data[9:0];
        REG_X_LEVEL:    cfg.x_level    <= cfg_data;
        REG_Y_LEVEL:    cfg.y_level    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Position scaling and error on tick transfer
  logic              is_touched;
  logic [19:0]       xs, ys;
  logic [15:0]       xpos, ypos;
  logic signed [ERR_W-1:0] ex_next, ey_next;

  always_comb begin
    is_touched = tick.pressure_code >= 12'(TOUCH_THRESHOLD);
    xs   = 20'(tick.x_code) * 20'(PLATE_WIDTH_MM);
    ys   = 20'(tick.y_code) * 20'(PLATE_HEIGHT_MM);
    xpos = is_touched ? xs[19:4] : CENTER_X;
    ypos = is_touched ? ys[19:4] : CENTER_Y;
    ex_next = $signed({1'b0, xpos}) - $signed({1'b0, cfg.setpoint_x});
    ey_next = $signed({1'b0, ypos}) - $signed({2'b0, cfg.setpoint_y});
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      ex      <= ex_next;
      ey      <= ey_next;
      touched <= is_touched;
    end
  end

  // Previous errors: updated when the result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
    end else if (emit_fire) begin
      px <= ex;
      py <= ey;
    end
  end

  // Operand selection
  logic signed [ERR_W-1:0]  e_sel, p_sel;
  logic signed [ERR_W:0]    diff;
  logic signed [ACC_W-1:0]  op_a;
  logic [15:0]              op_b;

  always_comb begin
    e_sel = (word.axis == AXIS_Y) ? ey : ex;
    p_sel = (word.axis == AXIS_Y) ? py : px;
    diff  = {e_sel[ERR_W-1], e_sel} - {p_sel[ERR_W-1], p_sel};
    unique case (word.a_sel)
      A_ERR:   op_a = ACC_W'(e_sel);
      A_DIFF:  op_a = ACC_W'(diff);
      A_ACC:   op_a = acc;
      default: op_a = acc;
    endcase
    unique case (word.b_sel)
      B_PGAIN: op_b = cfg.prop_gain;
      B_DGAIN: op_b = cfg.deriv_gain;
      B_CPM:   op_b = (word.axis == AXIS_Y) ? 16'(cfg.y_cpm) : 16'(cfg.x_cpm);
      default: op_b = cfg.prop_gain;
    endcase
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    if (word.mul_en) begin
      prod <= op_a * $signed({1'b0, op_b});
    end
  end

  // Accumulator takes the previous step's product
  always_ff @(posedge clk) begin
    unique case (word.acc_op)
      ACC_LOAD:  acc <= prod[ACC_W-1:0];
      ACC_ADD:   acc <= acc + prod[ACC_W-1:0];
      ACC_NLOAD: acc <= -prod[ACC_W-1:0];
      ACC_SUB:   acc <= acc - prod[ACC_W-1:0];
      default:   ;
    endcase
  end

  // Level plus floor(product / 65536), saturated to 0..PWM_TOP
  logic [15:0]       level;
  logic signed [36:0] sum;
  logic [15:0]       sat;

  always_comb begin
    level = (word.axis == AXIS_Y) ? cfg.y_level : cfg.x_level;
    sum   = $signed({21'b0, level}) + $signed({prod[PROD_W-1], prod[PROD_W-1:16]});
    if (sum < 0) begin
      sat = '0;
    end else if (sum > 37'(PWM_TOP)) begin
      sat = 16'(PWM_TOP);
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (word.out_x) begin
      res_x <= sat;
    end
    if (word.out_y) begin
      res_y <= sat;
    end
  end

  assign res.x_servo_compare = res_x;
  assign res.y_servo_compare = res_y;
  assign res.touched         = touched;

endmodule

`default_nettype wire

// ===== design/touch_plate_pd_servo_controller_unit.sv =====
// ---------------------------------------------------------------------------
// touch_plate_pd_servo_controller_unit
// Two-axis PD servo controller for a touch plate: microcoded sequencer
// driving a single-multiplier datapath.
// ---------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// tick      in         tick_valid / tick_stall      tick_t (pressure, x, y codes)
// result    out        result_valid / result_stall  result_t (x, y compare, touched)
// config    in         cfg_write (no handshake)     cfg_index, cfg_data
//
// One tick runs a 12-step microprogram that takes both axes through the
// one shared multiplier (5 steps per axis plus wait and emit).
// A tick is taken only at step 0; a held result stalls the emit step.
// Reset is synchronous; it restores register defaults and clears the
// previous errors and the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_plate_pd_servo_controller_unit
  import tpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick_valid,
  output logic             tick_stall,
  input  wire tick_t       tick,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [STEP_W-1:0] step, step_next;
  ucw_t              word;
  result_t           res;
  logic              tick_fire, slot_free, emit_fire;

  tpsc_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  tpsc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_fire (tick_fire),
    .tick      (tick),
    .emit_fire (emit_fire),
    .word      (word),
    .res       (res)
  );

  // Handshake strobes
  assign tick_stall = (word.jcond != JC_WAIT_IN);
  assign tick_fire  = tick_valid && !tick_stall;
  assign slot_free  = !result_valid || !result_stall;
  assign emit_fire  = word.emit && slot_free;

  // Step counter with conditional jumps
  always_comb begin
    unique case (word.jcond)
      JC_WAIT_IN:  step_next = tick_fire ? word.target : step;
      JC_WAIT_OUT: step_next = slot_free ? word.target : step;
      default:     step_next = word.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
